// ===== src/dj_transport_loop_cue_slip_defines.svh =====
// Assertion shorthands for the transport checker.
`ifndef DJ_TRANSPORT_LOOP_CUE_SLIP_DEFINES_SVH
`define DJ_TRANSPORT_LOOP_CUE_SLIP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DJT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DJT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/djt_pkg.sv =====
package djt_pkg;

    localparam int CUE_COUNT = 8;
    localparam int CUE_IDX_W = 3;
    localparam int DVD_W     = 35;
    localparam int DVS_W     = 34;
    localparam int CNT_W     = $clog2(DVD_W + 1);
    localparam int SUM_W     = 42;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 112;

    typedef enum logic [3:0] {
        CMD_MAP       = 4'd0,
        CMD_LOOP_IN   = 4'd1,
        CMD_LOOP_OUT  = 4'd2,
        CMD_AUTO_LOOP = 4'd3,
        CMD_EXIT_LOOP = 4'd4,
        CMD_SET_CUE   = 4'd5,
        CMD_CLEAR_CUE = 4'd6,
        CMD_JUMP_CUE  = 4'd7,
        CMD_BEAT_JUMP = 4'd8,
        CMD_SLIP      = 4'd9,
        CMD_READ_CUE  = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        REG_BEAT_PERIOD = 2'd0,
        REG_FIRST_BEAT  = 2'd1,
        REG_QUANTISE    = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PREP,
        ST_DIV,
        ST_SNAP,
        ST_APPLY,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic [30:0]        beat_period;
        logic signed [31:0] first_beat;
        logic               quantise;
    } cfg_t;

    typedef struct packed {
        logic [3:0]           command;
        logic signed [31:0]   position;
        logic signed [15:0]   beats;
        logic [CUE_IDX_W-1:0] cue_index;
        logic [7:0]           cue_colour;
        logic                 slip_on;
    } item_t;

    typedef struct packed {
        logic signed [31:0] play_position;
        logic signed [31:0] shadow_position;
        logic               accepted;
        logic               loop_active;
        logic signed [31:0] read_cue_position;
        logic               read_cue_set;
        logic [7:0]         read_cue_colour;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVS_W-1:0] rem;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic top_ones;
        logic top_zeros;
        top_ones  = &v[SUM_W-1:31];
        top_zeros = ~(|v[SUM_W-1:31]);
        if (top_ones || top_zeros)
        begin
            return v[31:0];
        end
        return v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage

// ===== src/djt_div.sv =====
module djt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  djt_pkg::div_req_t  req,
    output djt_pkg::div_rsp_t  rsp
);
    import djt_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W-1:0] rem_step;

    // Restoring remainder, one dividend bit a cycle.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_step = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== src/djt_core.sv =====
module djt_core (
    input  logic           clk,
    input  logic           rst_n,
    input  djt_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  djt_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output djt_pkg::res_t  out_res
);
    import djt_pkg::*;

    seq_state_t state_reg, state_next;
    item_t      item_reg;
    cmd_t       cmd;

    logic               seen_reg, loop_reg, slip_reg;
    logic signed [31:0] lp_reg, po_reg, so_reg, cur_reg, ls_reg, le_reg;
    logic signed [31:0] cue_pos_reg [CUE_COUNT];
    logic               cue_set_reg [CUE_COUNT];
    logic [7:0]         cue_col_reg [CUE_COUNT];

    logic signed [31:0] p_reg, x_reg, point_reg, w_reg;
    logic signed [32:0] len_reg;
    logic signed [46:0] mul_reg;
    logic signed [39:0] bt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic               neg_reg, use_div_reg;
    logic               ok_reg, rd_set_reg;
    logic signed [31:0] rd_pos_reg;
    logic [7:0]         rd_col_reg;
    logic               out_valid_reg;
    res_t               res_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               grid, is_map, need_div, slot_ok, load_out;
    logic signed [31:0] p_sum, x_sel, snapped, w_c;
    logic signed [32:0] len_c, d_c;
    logic [32:0]        mag_c;
    logic signed [46:0] mul_c;
    logic [DVD_W-1:0]   np_c;
    logic [DVS_W-1:0]   off_c;
    logic [46:0]        prod_mag;
    logic [38:0]        prod_rnd;
    logic signed [39:0] bt_c;
    logic signed [SUM_W-1:0] np_s, delta_c;
    logic signed [31:0] po_shift, so_shift, cur_bt, end_c, lp_so, cue_tgt;

    assign cmd  = cmd_t'(item_reg.command);
    assign grid = cfg.quantise && (cfg.beat_period != '0);

    djt_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // Setup: platter sum, loop length, beat product.
    always_comb
    begin
        p_sum = sat32(SUM_W'(item_reg.position) + SUM_W'(po_reg));
        x_sel = (cmd == CMD_AUTO_LOOP) ? cur_reg : item_reg.position;
        len_c = 33'(le_reg) - 33'(ls_reg);
        mul_c = 47'(item_reg.beats) * 47'($signed({1'b0, cfg.beat_period}));
    end

    // Divider request: floored wrap or grid snap.
    always_comb
    begin
        is_map = (cmd == CMD_MAP);
        d_c    = is_map ? (33'(p_reg) - 33'(ls_reg)) : (33'(x_reg) - 33'(cfg.first_beat));
        mag_c  = d_c[32] ? 33'(-d_c) : 33'(d_c);
        case (cmd)
            CMD_MAP:       need_div = loop_reg && (len_reg > 0);
            CMD_LOOP_IN,
            CMD_LOOP_OUT,
            CMD_SET_CUE,
            CMD_AUTO_LOOP: need_div = grid;
            default:       need_div = 1'b0;
        endcase
        div_req.start    = (state_reg == ST_PREP) && need_div;
        div_req.dividend = is_map ? DVD_W'(mag_c)
                                  : DVD_W'({mag_c, 1'b0}) + DVD_W'(cfg.beat_period);
        div_req.divisor  = is_map ? DVS_W'(len_reg[32:0]) : DVS_W'({cfg.beat_period, 1'b0});
    end

    // Snap point, wrapped position, rounded beat time.
    always_comb
    begin
        np_c     = (dvd_reg - DVD_W'(div_rsp.rem)) >> 1;
        np_s     = $signed(SUM_W'(np_c));
        snapped  = neg_reg ? sat32(SUM_W'(cfg.first_beat) - np_s)
                           : sat32(SUM_W'(cfg.first_beat) + np_s);
        if (!neg_reg || (div_rsp.rem == '0))
            off_c = div_rsp.rem;
        else
            off_c = DVS_W'(len_reg[32:0]) - div_rsp.rem;
        w_c      = ls_reg + $signed(off_c[31:0]);
        prod_mag = mul_reg[46] ? 47'(-mul_reg) : 47'(mul_reg);
        prod_rnd = 39'((prod_mag + 47'd128) >> 8);
        bt_c     = mul_reg[46] ? -$signed({1'b0, prod_rnd}) : $signed({1'b0, prod_rnd});
    end

    // State update sums.
    always_comb
    begin
        slot_ok = int'(item_reg.cue_index) < CUE_COUNT;
        cue_tgt = cue_pos_reg[item_reg.cue_index];
        case (cmd)
            CMD_MAP:      delta_c = SUM_W'(w_reg) - SUM_W'(p_reg);
            CMD_JUMP_CUE: delta_c = SUM_W'(cue_tgt) - SUM_W'(cur_reg);
            default:      delta_c = SUM_W'(bt_reg);
        endcase
        po_shift = sat32(SUM_W'(po_reg) + delta_c);
        so_shift = sat32(SUM_W'(so_reg) + delta_c);
        cur_bt   = sat32(SUM_W'(cur_reg) + SUM_W'(bt_reg));
        end_c    = sat32(SUM_W'(point_reg) + SUM_W'(bt_reg));
        lp_so    = sat32(SUM_W'(lp_reg) + SUM_W'(so_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_START;
            ST_START: state_next = ST_PREP;
            ST_PREP:  state_next = need_div ? ST_DIV : ST_SNAP;
            ST_DIV:   if (div_rsp.done) state_next = ST_SNAP;
            ST_SNAP:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            loop_reg      <= 1'b0;
            slip_reg      <= 1'b0;
            lp_reg        <= '0;
            po_reg        <= '0;
            so_reg        <= '0;
            cur_reg       <= '0;
            ls_reg        <= '0;
            le_reg        <= '0;
            for (int i = 0; i < CUE_COUNT; i++)
            begin
                cue_pos_reg[i] <= '0;
                cue_set_reg[i] <= 1'b0;
                cue_col_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_APPLY)
            begin
                case (cmd)
                    CMD_MAP:
                    begin
                        lp_reg   <= item_reg.position;
                        seen_reg <= 1'b1;
                        if (use_div_reg)
                        begin
                            po_reg  <= po_shift;
                            if (!slip_reg) so_reg <= so_shift;
                            cur_reg <= w_reg;
                        end
                        else
                            cur_reg <= p_reg;
                    end
                    CMD_LOOP_IN:
                    begin
                        ls_reg   <= point_reg;
                        loop_reg <= 1'b0;
                    end
                    CMD_LOOP_OUT:
                        if (point_reg > ls_reg)
                        begin
                            le_reg   <= point_reg;
                            loop_reg <= 1'b1;
                        end
                    CMD_AUTO_LOOP:
                        if ((cfg.beat_period != '0) && (item_reg.beats > 0))
                        begin
                            ls_reg   <= point_reg;
                            le_reg   <= end_c;
                            loop_reg <= 1'b1;
                        end
                    CMD_EXIT_LOOP:
                        if (loop_reg)
                        begin
                            loop_reg <= 1'b0;
                            if (slip_reg) po_reg <= so_reg;
                        end
                    CMD_SET_CUE:
                        if (slot_ok)
                        begin
                            cue_pos_reg[item_reg.cue_index] <= point_reg;
                            cue_set_reg[item_reg.cue_index] <= 1'b1;
                            cue_col_reg[item_reg.cue_index] <= item_reg.cue_colour;
                        end
                    CMD_CLEAR_CUE:
                        if (slot_ok)
                        begin
                            cue_pos_reg[item_reg.cue_index] <= '0;
                            cue_set_reg[item_reg.cue_index] <= 1'b0;
                            cue_col_reg[item_reg.cue_index] <= '0;
                        end
                    CMD_JUMP_CUE:
                        if (slot_ok && cue_set_reg[item_reg.cue_index])
                        begin
                            po_reg  <= po_shift;
                            if (!slip_reg) so_reg <= so_shift;
                            cur_reg <= cue_tgt;
                        end
                    CMD_BEAT_JUMP:
                        if (cfg.beat_period != '0)
                        begin
                            po_reg  <= po_shift;
                            if (!slip_reg) so_reg <= so_shift;
                            cur_reg <= cur_bt;
                        end
                    CMD_SLIP:
                        if (item_reg.slip_on != slip_reg)
                        begin
                            slip_reg <= item_reg.slip_on;
                            if (item_reg.slip_on)
                                so_reg <= po_reg;
                            else
                            begin
                                po_reg <= so_reg;
                                if (seen_reg) cur_reg <= lp_so;
                            end
                        end
                    default: ;
                endcase
            end
        end
    end

    // Work registers and result payload: no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid) item_reg <= in_item;
            ST_START:
            begin
                p_reg   <= p_sum;
                x_reg   <= x_sel;
                len_reg <= len_c;
                mul_reg <= mul_c;
            end
            ST_PREP:
            begin
                neg_reg     <= d_c[32];
                dvd_reg     <= div_req.dividend;
                use_div_reg <= need_div;
            end
            ST_SNAP:
            begin
                point_reg <= use_div_reg ? snapped : x_reg;
                w_reg     <= w_c;
                bt_reg    <= bt_c;
            end
            ST_APPLY:
            begin
                rd_pos_reg <= '0;
                rd_set_reg <= 1'b0;
                rd_col_reg <= '0;
                case (cmd)
                    CMD_MAP,
                    CMD_LOOP_IN:   ok_reg <= 1'b1;
                    CMD_LOOP_OUT:  ok_reg <= point_reg > ls_reg;
                    CMD_AUTO_LOOP: ok_reg <= (cfg.beat_period != '0) && (item_reg.beats > 0);
                    CMD_EXIT_LOOP: ok_reg <= loop_reg;
                    CMD_SET_CUE,
                    CMD_CLEAR_CUE: ok_reg <= slot_ok;
                    CMD_JUMP_CUE:  ok_reg <= slot_ok && cue_set_reg[item_reg.cue_index];
                    CMD_BEAT_JUMP: ok_reg <= cfg.beat_period != '0;
                    CMD_SLIP:      ok_reg <= item_reg.slip_on != slip_reg;
                    CMD_READ_CUE:
                    begin
                        ok_reg <= slot_ok;
                        if (slot_ok)
                        begin
                            rd_pos_reg <= cue_tgt;
                            rd_set_reg <= cue_set_reg[item_reg.cue_index];
                            rd_col_reg <= cue_col_reg[item_reg.cue_index];
                        end
                    end
                    default:       ok_reg <= 1'b0;
                endcase
            end
            ST_OUT:
                if (load_out)
                begin
                    res_reg.play_position     <= cur_reg;
                    res_reg.shadow_position   <= lp_so;
                    res_reg.accepted          <= ok_reg;
                    res_reg.loop_active       <= loop_reg;
                    res_reg.read_cue_position <= rd_pos_reg;
                    res_reg.read_cue_set      <= rd_set_reg;
                    res_reg.read_cue_colour   <= rd_col_reg;
                end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== src/dj_transport_loop_cue_slip.sv =====
// Channel  | Dir | Handshake              | Payload
// s        | in  | s_tvalid / s_tready    | s_tdata request fields, s_tuser command
// m        | out | m_tvalid / m_tready    | m_tdata result fields
// cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request passes the sequencer states start, prep, snap, apply and out in turn; with a
// divide (wrap or snap) it also waits in the divide state between prep and snap, while the
// serial remainder unit works through the 35-bit dividend one bit at a time and flags done.
// s_tready is high only while the sequencer is idle; the result register
// holds a finished result until m_tready takes it, while the next request is taken.
// rst_n clears all deck state and the cue table at once; cfg_ready is always high.
module dj_transport_loop_cue_slip (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [31:0] position, [47:32] beats, [50:48] cue_index, [58:51] cue_colour,
    // [59] slip_on, [63:60] zero
    input  logic [djt_pkg::S_DATA_W-1:0] s_tdata,
    // [3:0] command
    input  logic [3:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] play_position, [63:32] shadow_position, [64] accepted,
    // [65] loop_active, [97:66] read_cue_position, [98] read_cue_set,
    // [106:99] read_cue_colour, [111:107] zero
    output logic [djt_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);
    import djt_pkg::*;

    cfg_t  cfg_reg;
    item_t in_item;
    res_t  out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_BEAT_PERIOD: cfg_reg.beat_period <= cfg_data[30:0];
                REG_FIRST_BEAT:  cfg_reg.first_beat  <= $signed(cfg_data);
                REG_QUANTISE:    cfg_reg.quantise    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_item.command    = s_tuser;
        in_item.position   = $signed(s_tdata[31:0]);
        in_item.beats      = $signed(s_tdata[47:32]);
        in_item.cue_index  = s_tdata[50:48];
        in_item.cue_colour = s_tdata[58:51];
        in_item.slip_on    = s_tdata[59];
    end

    djt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'b0, out_res.read_cue_colour, out_res.read_cue_set,
                      out_res.read_cue_position, out_res.loop_active, out_res.accepted,
                      out_res.shadow_position, out_res.play_position};

endmodule

// ===== src/djt_checker.sv =====
`include "dj_transport_loop_cue_slip_defines.svh"

module djt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    // One request at a time: drop ready after a take.
    `DJT_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready after request")

    `DJT_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result moved while stalled")

    // Empty or unread slot reports zero position and colour.
    `DJT_ASSERT_SAME(a_read_zero, m_tvalid && !m_tdata[98], (m_tdata[97:66] == 32'd0) && (m_tdata[106:99] == 8'd0), "read fields not zero")

    `DJT_ASSERT_SAME(a_read_needs_ok, m_tvalid && !m_tdata[64], !m_tdata[98], "cue read on rejected request")

endmodule

bind dj_transport_loop_cue_slip djt_checker u_djt_checker (.*);

// ===== tb/dj_transport_loop_cue_slip_tb.sv =====
module dj_transport_loop_cue_slip_tb;
    import djt_pkg::*;

    localparam int RANDOM_REQS = 1100;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct {
        logic [3:0]         cmd;
        logic signed [31:0] pos;
        logic signed [15:0] beats;
        logic [2:0]         idx;
        logic [7:0]         colour;
        logic               slip;
        logic               chk;
        logic               acc;
        logic               lp;
    } req_row_t;

    typedef struct packed {
        logic [31:0] play;
        logic [31:0] shadow;
        logic        acc;
        logic        lp;
        logic [31:0] rpos;
        logic        rset;
        logic [7:0]  rcol;
    } deck_res_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [3:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    dj_transport_loop_cue_slip u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // deck model state
    longint      period_q;
    longint      grid_origin;
    bit          snap_on;
    bit          seen_platter;
    longint      platter_q, play_off, shadow_off, cur_pos, lp_start, lp_end;
    bit          lp_on, slip_q;
    longint      cue_pos [8];
    bit          cue_set [8];
    logic [7:0]  cue_col [8];

    deck_res_t   pending_results [$];
    req_row_t    pending_checks [$];
    int          errors = 0;
    int          results_seen = 0;
    int          accepted_cnt = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint grid_snap(longint p);
        longint d, m, n;
        if (!snap_on || period_q == 0) return p;
        d = p - grid_origin;
        m = d < 0 ? -d : d;
        n = (2 * m + period_q) / (2 * period_q);
        if (d < 0) n = -n;
        return sat(grid_origin + n * period_q);
    endfunction

    function automatic longint beat_time(longint b);
        longint pr, m, r;
        pr = b * period_q;
        m = pr < 0 ? -pr : pr;
        r = (m + 128) >>> 8;
        return pr < 0 ? -r : r;
    endfunction

    function automatic void shift_deck(longint delta);
        play_off = sat(play_off + delta);
        if (!slip_q) shadow_off = sat(shadow_off + delta);
    endfunction

    function automatic void deck_reset();
        period_q = 0; grid_origin = 0; snap_on = 0;
        seen_platter = 0; platter_q = 0; play_off = 0; shadow_off = 0; cur_pos = 0;
        lp_start = 0; lp_end = 0; lp_on = 0; slip_q = 0;
        for (int i = 0; i < 8; i++)
        begin
            cue_pos[i] = 0; cue_set[i] = 0; cue_col[i] = 0;
        end
    endfunction

    function automatic deck_res_t deck_step(req_row_t r);
        deck_res_t o;
        longint    p, len, off, w, e, s, d;
        bit        ok;
        ok = 0;
        o.rpos = '0; o.rset = 0; o.rcol = '0;
        case (r.cmd)
            CMD_MAP:
            begin
                platter_q = r.pos; seen_platter = 1;
                p = sat(longint'(r.pos) + play_off);
                len = lp_end - lp_start;
                if (lp_on && len > 0)
                begin
                    off = (p - lp_start) % len;
                    if (off < 0) off += len;
                    w = lp_start + off;
                    if (w != p) shift_deck(w - p);
                    p = w;
                end
                cur_pos = p; ok = 1;
            end
            CMD_LOOP_IN:
            begin
                lp_start = grid_snap(r.pos); lp_on = 0; ok = 1;
            end
            CMD_LOOP_OUT:
            begin
                e = grid_snap(r.pos);
                if (e > lp_start)
                begin
                    lp_end = e; lp_on = 1; ok = 1;
                end
            end
            CMD_AUTO_LOOP:
                if (period_q != 0 && r.beats > 0)
                begin
                    s = grid_snap(cur_pos);
                    lp_start = s; lp_end = sat(s + beat_time(r.beats));
                    lp_on = 1; ok = 1;
                end
            CMD_EXIT_LOOP:
                if (lp_on)
                begin
                    lp_on = 0;
                    if (slip_q) play_off = shadow_off;
                    ok = 1;
                end
            CMD_SET_CUE:
            begin
                cue_pos[r.idx] = grid_snap(r.pos); cue_set[r.idx] = 1;
                cue_col[r.idx] = r.colour; ok = 1;
            end
            CMD_CLEAR_CUE:
            begin
                cue_pos[r.idx] = 0; cue_set[r.idx] = 0; cue_col[r.idx] = 0; ok = 1;
            end
            CMD_JUMP_CUE:
                if (cue_set[r.idx])
                begin
                    shift_deck(cue_pos[r.idx] - cur_pos);
                    cur_pos = cue_pos[r.idx]; ok = 1;
                end
            CMD_BEAT_JUMP:
                if (period_q != 0)
                begin
                    d = beat_time(r.beats);
                    shift_deck(d); cur_pos = sat(cur_pos + d); ok = 1;
                end
            CMD_SLIP:
                if (r.slip != slip_q)
                begin
                    slip_q = r.slip;
                    if (r.slip) shadow_off = play_off;
                    else
                    begin
                        play_off = shadow_off;
                        if (seen_platter) cur_pos = sat(platter_q + play_off);
                    end
                    ok = 1;
                end
            CMD_READ_CUE:
            begin
                o.rpos = cue_pos[r.idx]; o.rset = cue_set[r.idx]; o.rcol = cue_col[r.idx];
                ok = 1;
            end
            default: ;
        endcase
        o.play = cur_pos;
        o.shadow = sat(platter_q + shadow_off);
        o.acc = ok;
        o.lp = lp_on;
        return o;
    endfunction

    always @(posedge clk) cycles <= cycles + 1;

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (m_tready && $urandom_range(0, 3) == 0)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // check results on each accepted transfer
    always @(posedge clk)
    begin
        deck_res_t exp_r, got;
        req_row_t  row;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.play   = m_tdata[31:0];
            got.shadow = m_tdata[63:32];
            got.acc    = m_tdata[64];
            got.lp     = m_tdata[65];
            got.rpos   = m_tdata[97:66];
            got.rset   = m_tdata[98];
            got.rcol   = m_tdata[106:99];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result %h", $time, m_tdata);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                row = pending_checks.pop_front();
                if (got.acc) accepted_cnt++;
                if (row.chk && (row.acc !== exp_r.acc || row.lp !== exp_r.lp))
                begin
                    errors++;
                    $display("%0t directed row: expected acc %0d loop %0d, predictor %0d %0d",
                             $time, row.acc, row.lp, exp_r.acc, exp_r.lp);
                end
                if (got !== exp_r)
                begin
                    errors++;
                    $display("%0t mismatch: expected play %h shadow %h acc %b loop %b rd %h/%b/%h",
                             $time, exp_r.play, exp_r.shadow, exp_r.acc, exp_r.lp,
                             exp_r.rpos, exp_r.rset, exp_r.rcol);
                    $display("%0t           actual play %h shadow %h acc %b loop %b rd %h/%b/%h",
                             $time, got.play, got.shadow, got.acc, got.lp,
                             got.rpos, got.rset, got.rcol);
                end
            end
        end
    end

    task automatic send_req(req_row_t r);
        int gap;
        if ($urandom_range(0, 2) == 0)
        begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {4'b0, r.slip, r.colour, r.idx, r.beats, r.pos};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(deck_step(r));
        pending_checks.push_back(r);
    endtask

    task automatic drain();
        int n;
        n = 0;
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        while (n < 60)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BEAT_PERIOD: period_q = val[30:0];
            REG_FIRST_BEAT:  grid_origin = $signed(val);
            REG_QUANTISE:    snap_on = val[0];
            default: ;
        endcase
    endtask

    function automatic req_row_t mk(logic [3:0] c, logic signed [31:0] p,
                                    logic signed [15:0] b, logic [2:0] i, logic [7:0] col,
                                    logic sl, logic chk, logic acc, logic lp);
        req_row_t r;
        r.cmd = c; r.pos = p; r.beats = b; r.idx = i; r.colour = col; r.slip = sl;
        r.chk = chk; r.acc = acc; r.lp = lp;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'sh8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    function automatic req_row_t rand_req();
        req_row_t r;
        int       k;
        k = $urandom_range(0, 99);
        r = mk(CMD_MAP, rand_pos(), 16'($urandom()), 3'($urandom()), 8'($urandom()),
               1'($urandom()), 0, 0, 0);
        if (k < 45)      r.cmd = CMD_MAP;
        else if (k < 98) r.cmd = 4'($urandom_range(1, 10));
        else             r.cmd = 4'($urandom_range(11, 15));
        if ($urandom_range(0, 3) != 0)
            r.beats = 16'($signed($urandom_range(0, 4096)) - 1024);
        return r;
    endfunction

    req_row_t directed [] = '{
        // fresh deck: empty cue, no loop, no grid
        mk(CMD_READ_CUE,  0, 0, 3'd7, 0, 0, 1, 1, 0),
        mk(CMD_JUMP_CUE,  0, 0, 3'd2, 0, 0, 1, 0, 0),
        mk(CMD_EXIT_LOOP, 0, 0, 3'd0, 0, 0, 1, 0, 0),
        mk(CMD_AUTO_LOOP, 0, 16'sd256, 3'd0, 0, 0, 1, 0, 0),
        mk(CMD_BEAT_JUMP, 0, 16'sd256, 3'd0, 0, 0, 1, 0, 0),
        mk(CMD_SLIP,      0, 0, 3'd0, 0, 0, 1, 0, 0),
        mk(4'd15,         32'sh7FFF_FFFF, 16'sh7FFF, 3'd7, 8'hFF, 1, 1, 0, 0),
        mk(CMD_MAP,       32'sh7FFF_FFFF, 0, 3'd0, 0, 0, 1, 1, 0),
        mk(CMD_MAP,       32'sh8000_0000, 0, 3'd0, 0, 0, 1, 1, 0),
        mk(CMD_SET_CUE,   32'sh0001_0000, 0, 3'd7, 8'hFF, 0, 1, 1, 0),
        mk(CMD_READ_CUE,  0, 0, 3'd7, 0, 0, 1, 1, 0),
        mk(CMD_CLEAR_CUE, 0, 0, 3'd3, 0, 0, 1, 1, 0),
        mk(CMD_LOOP_IN,   32'sh0002_0000, 0, 3'd0, 0, 0, 1, 1, 0),
        mk(CMD_LOOP_OUT,  32'sh0001_0000, 0, 3'd0, 0, 0, 1, 0, 0),
        mk(CMD_LOOP_OUT,  32'sh0003_0000, 0, 3'd0, 0, 0, 1, 1, 1),
        mk(CMD_MAP,       32'sh0007_8000, 0, 3'd0, 0, 0, 0, 0, 0),
        mk(CMD_MAP,       -32'sh0005_0000, 0, 3'd0, 0, 0, 0, 0, 0),
        mk(CMD_SLIP,      0, 0, 3'd0, 0, 1, 1, 1, 1),
        mk(CMD_MAP,       32'sh0004_0000, 0, 3'd0, 0, 0, 0, 0, 0),
        mk(CMD_EXIT_LOOP, 0, 0, 3'd0, 0, 0, 1, 1, 0),
        mk(CMD_JUMP_CUE,  0, 0, 3'd7, 0, 0, 1, 1, 0),
        mk(CMD_SLIP,      0, 0, 3'd0, 0, 0, 1, 1, 0),
        mk(CMD_MAP,       32'sh0001_0000, 0, 3'd0, 0, 0, 0, 0, 0)
    };

    initial
    begin
        int phase;
        deck_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_req(directed[i]);
        drain();

        // grid phase with extreme beat counts
        write_reg(REG_BEAT_PERIOD, 32'h0000_8000);
        write_reg(REG_FIRST_BEAT,  32'h0000_1000);
        write_reg(REG_QUANTISE,    32'h1);
        send_req(mk(CMD_AUTO_LOOP, 0, 16'sh7FFF, 0, 0, 0, 0, 0, 0));
        send_req(mk(CMD_AUTO_LOOP, 0, 16'sh8000, 0, 0, 0, 1, 0, 1));
        send_req(mk(CMD_BEAT_JUMP, 0, 16'sh8000, 0, 0, 0, 1, 1, 1));
        send_req(mk(CMD_SET_CUE, 32'sh0001_2345, 0, 3'd0, 8'h5A, 0, 1, 1, 1));

        // long receiver hold-off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 18; i++) send_req(rand_req());
        join

        for (phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0: begin
                    write_reg(REG_BEAT_PERIOD, 32'h7FFF_FFFF);
                    write_reg(REG_FIRST_BEAT,  32'h8000_0000);
                end
                1: begin
                    write_reg(REG_BEAT_PERIOD, 32'h0000_0001);
                    write_reg(REG_FIRST_BEAT,  32'h7FFF_FFFF);
                    write_reg(REG_QUANTISE,    32'h0);
                end
                2: write_reg(REG_BEAT_PERIOD, 32'h0);
                default: begin
                    write_reg(REG_BEAT_PERIOD, $urandom_range(1, 32'h0004_0000));
                    write_reg(REG_FIRST_BEAT,  $urandom());
                    write_reg(REG_QUANTISE,    $urandom_range(0, 1));
                end
            endcase
            for (int i = 0; i < RANDOM_REQS / 6; i++) send_req(rand_req());
        end
        drain();

        $display("Covered %0d results (%0d accepted) over all commands, loop wrap, slip,",
                 results_seen, accepted_cnt);
        $display("cue table and grid snapping at several register settings.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
